>>> rtl/core/dda_raycast_column_macros.svh
// ----------------------------------------------------------------------------
// dda_raycast_column_macros
// Assertion macros shared by the raycaster RTL.
// ----------------------------------------------------------------------------
`ifndef DDA_RAYCAST_COLUMN_MACROS_SVH
`define DDA_RAYCAST_COLUMN_MACROS_SVH
`ifndef SYNTHESIS
`define DDA_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("raycaster check failed");
`define DDA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("raycaster check failed");
`else
`define DDA_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define DDA_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

>>> rtl/core/dda_pkg.sv
// ----------------------------------------------------------------------------
// dda_pkg
// Shared widths, register codes, divider types and color helpers.
// ----------------------------------------------------------------------------
package dda_pkg;
	localparam int NUM_W  = 25;   // dividend width
	localparam int DEN_W  = 27;   // divisor width
	localparam int CNT_W  = 5;
	localparam int RX_W   = 27;   // ray component, signed Q.14
	localparam int CAM_W  = 26;
	localparam int DLT_W  = 33;   // delta incl. saturated 2^32
	localparam int SIDE_W = 42;
	localparam int POS_W  = 10;   // signed map cell coordinate
	localparam int DEPTH_W = 18;

	localparam logic [DLT_W-1:0]   DELTA_SAT = {1'b1, 32'd0};
	localparam logic [NUM_W-1:0]   DELTA_NUM = {1'b1, 24'd0};
	localparam logic [DEPTH_W-1:0] DEPTH_MAX = '1;

	localparam logic [2:0] REG_T1_NS = 3'd0;
	localparam logic [2:0] REG_T1_EW = 3'd1;
	localparam logic [2:0] REG_T2_NS = 3'd2;
	localparam logic [2:0] REG_T2_EW = 3'd3;
	localparam logic [2:0] REG_FOG   = 3'd4;

	localparam logic [7:0] FOG_MUL = 8'd120;

	typedef struct packed {
		logic             start;
		logic [NUM_W-1:0] num;
		logic [DEN_W-1:0] den;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [NUM_W-1:0] quo;
	} div_rsp_t;

	function automatic logic [7:0] dim_chan(input logic [7:0] c);
		logic [15:0] p;
		p = c * FOG_MUL;
		return p[15:8];
	endfunction

	function automatic logic [23:0] dim_color(input logic [23:0] c);
		return {dim_chan(c[23:16]), dim_chan(c[15:8]), dim_chan(c[7:0])};
	endfunction
endpackage

>>> rtl/core/dda_ch_if.sv
// ----------------------------------------------------------------------------
// dda_ch_if
// Valid/ready channels for cast requests and column results.
// ----------------------------------------------------------------------------
interface dda_in_if;
	logic               valid;
	logic               ready;
	logic               mode;
	logic [8:0]         column;
	logic [15:0]        pos_x;
	logic [15:0]        pos_y;
	logic signed [15:0] dir_x;
	logic signed [15:0] dir_y;
	logic signed [15:0] plane_x;
	logic signed [15:0] plane_y;
	logic [4:0]         cell_col;
	logic [4:0]         cell_row;
	logic [7:0]         cell_value;

	modport source (output valid, mode, column, pos_x, pos_y, dir_x, dir_y, plane_x,
		plane_y, cell_col, cell_row, cell_value, input ready);
	modport sink (input valid, mode, column, pos_x, pos_y, dir_x, dir_y, plane_x,
		plane_y, cell_col, cell_row, cell_value, output ready);
endinterface

interface dda_out_if;
	logic        valid;
	logic        ready;
	logic [8:0]  out_column;
	logic [17:0] depth;
	logic [7:0]  wall_top;
	logic [7:0]  wall_bottom;
	logic [7:0]  floor_split;
	logic [23:0] wall_color;
	logic        hit_side;

	modport source (output valid, out_column, depth, wall_top, wall_bottom, floor_split,
		wall_color, hit_side, input ready);
	modport sink (input valid, out_column, depth, wall_top, wall_bottom, floor_split,
		wall_color, hit_side, output ready);
endinterface

>>> rtl/core/dda_div.sv
// ----------------------------------------------------------------------------
// dda_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module dda_div import dda_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);
	logic [DEN_W-1:0] rem_q;
	logic [NUM_W-1:0] quo_q;
	logic [DEN_W-1:0] den_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [DEN_W:0]   trial;
	logic             ge;

	assign trial = {rem_q, quo_q[NUM_W-1]};
	assign ge    = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(NUM_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			quo_q <= req.num;
			den_q <= req.den;
		end else if (busy_q) begin
			rem_q <= ge ? DEN_W'(trial - {1'b0, den_q}) : trial[DEN_W-1:0];
			quo_q <= {quo_q[NUM_W-2:0], ge};
		end
	end

	assign rsp.done = done_q;
	assign rsp.quo  = quo_q;
endmodule

>>> rtl/core/dda_map.sv
// ----------------------------------------------------------------------------
// dda_map
// Map cell store: one write port, one registered read port.
// ----------------------------------------------------------------------------
module dda_map import dda_pkg::*; #(
	parameter int DEPTH = 1024,
	parameter int AW    = 10
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [7:0]    wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [7:0]    rdata
);
	logic [7:0] mem_q [DEPTH];
	logic [7:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;
endmodule

>>> rtl/core/dda_raycast_column.sv
// Each DDA step passes through the STEP, RD and CHK states; a step that leaves
// the map skips RD and CHK. Three divisions share one bit-serial divider; the
// camera coordinate comes from a reciprocal multiply. A map write is taken as
// an input transfer with mode low. One cast is in work at a time; the result
// register lets the next item enter while a result waits. arst_n clears control
// state and resets the configuration registers; the map is undefined until
// written.
// ----------------------------------------------------------------------------
// dda_raycast_column
// Grid-map DDA raycaster for one screen column.
// ----------------------------------------------------------------------------
`include "dda_raycast_column_macros.svh"
module dda_raycast_column import dda_pkg::*; #(
	parameter int MAP_WIDTH    = 32,
	parameter int MAP_HEIGHT   = 32,
	parameter int SCREEN_WIDTH = 320,
	parameter int VIEW_HEIGHT  = 240
) (
	input  logic        clk,
	input  logic        arst_n,
	dda_in_if.sink      cast_in,
	dda_out_if.source   cast_out,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	localparam int MAP_DEPTH = MAP_WIDTH * MAP_HEIGHT;
	localparam int MAP_AW    = $clog2(MAP_DEPTH);
	localparam int STEP_MAX  = 2 * (MAP_WIDTH + MAP_HEIGHT) + 4;
	localparam int STEP_W    = $clog2(STEP_MAX + 1);
	localparam int HALF_VH   = VIEW_HEIGHT / 2;
	// column * 32768 / SCREEN_WIDTH as (column * CAM_M) >> (CAM_S - 15), exact
	// for any column below 512 and screen width up to 4096
	localparam int          CAM_S = 36;
	localparam logic [36:0] CAM_M = 37'(((64'd1 << CAM_S) + 64'(SCREEN_WIDTH) - 64'd1)
		/ 64'(SCREEN_WIDTH));

	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_CAM   = 4'd1;
	localparam logic [3:0] ST_RAYX  = 4'd2;
	localparam logic [3:0] ST_RAYY  = 4'd3;
	localparam logic [3:0] ST_DX    = 4'd4;
	localparam logic [3:0] ST_DY    = 4'd5;
	localparam logic [3:0] ST_SIDEX = 4'd6;
	localparam logic [3:0] ST_SIDEY = 4'd7;
	localparam logic [3:0] ST_STEP  = 4'd8;
	localparam logic [3:0] ST_RD    = 4'd9;
	localparam logic [3:0] ST_CHK   = 4'd10;
	localparam logic [3:0] ST_PERP  = 4'd11;
	localparam logic [3:0] ST_LINE  = 4'd12;
	localparam logic [3:0] ST_FIN   = 4'd13;

	logic [3:0] state_q;

	// configuration
	logic [23:0] t1_ns_q, t1_ew_q, t2_ns_q, t2_ew_q;
	logic [17:0] fog_q;
	logic        cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			t1_ns_q <= '0;
			t1_ew_q <= '0;
			t2_ns_q <= '0;
			t2_ew_q <= '0;
			fog_q   <= 18'd6144;
		end else if (cfg_wr) begin
			case (paddr[4:2])
				REG_T1_NS: t1_ns_q <= pwdata[23:0];
				REG_T1_EW: t1_ew_q <= pwdata[23:0];
				REG_T2_NS: t2_ns_q <= pwdata[23:0];
				REG_T2_EW: t2_ew_q <= pwdata[23:0];
				REG_FOG:   fog_q   <= pwdata[17:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[4:2])
			REG_T1_NS: prdata = {8'd0, t1_ns_q};
			REG_T1_EW: prdata = {8'd0, t1_ew_q};
			REG_T2_NS: prdata = {8'd0, t2_ns_q};
			REG_T2_EW: prdata = {8'd0, t2_ew_q};
			REG_FOG:   prdata = {14'd0, fog_q};
			default:   prdata = '0;
		endcase
	end

	// captured item
	logic [8:0]         col_q;
	logic [15:0]        px_q, py_q;
	logic signed [15:0] dir_x_q, dir_y_q, plane_x_q, plane_y_q;

	// working registers
	logic signed [CAM_W-1:0] cam_q;
	logic signed [RX_W-1:0]  rx_q, ry_q;
	logic [DLT_W-1:0]        dx_q, dy_q;
	logic [SIDE_W-1:0]       sx_q, sy_q;
	logic signed [POS_W-1:0] mx_q, my_q;
	logic                    side_q;
	logic [STEP_W-1:0]       k_q;
	logic [7:0]              wtype_q;
	logic [DEPTH_W-1:0]      perp_q;
	logic [NUM_W-1:0]        line_q;

	logic             div_start_q;
	logic [NUM_W-1:0] div_num_q;
	logic [DEN_W-1:0] div_den_q;
	div_req_t         div_req;
	div_rsp_t         div_rsp;

	assign div_req.start = div_start_q;
	assign div_req.num   = div_num_q;
	assign div_req.den   = div_den_q;

	dda_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// map store
	logic              map_we, map_re;
	logic [MAP_AW-1:0] map_waddr, map_raddr;
	logic [7:0]        map_rdata;
	logic              in_acc, wr_in_map;

	assign in_acc    = cast_in.valid & cast_in.ready;
	assign wr_in_map = (9'(cast_in.cell_col) < 9'(MAP_WIDTH))
		&& (9'(cast_in.cell_row) < 9'(MAP_HEIGHT));
	assign map_we    = in_acc & ~cast_in.mode & wr_in_map;
	assign map_waddr = MAP_AW'(int'(cast_in.cell_row) * MAP_WIDTH + int'(cast_in.cell_col));
	assign map_re    = (state_q == ST_RD);
	assign map_raddr = MAP_AW'(int'(my_q) * MAP_WIDTH + int'(mx_q));

	dda_map #(.DEPTH(MAP_DEPTH), .AW(MAP_AW)) u_map (
		.clk   (clk),
		.we    (map_we),
		.waddr (map_waddr),
		.wdata (cast_in.cell_value),
		.re    (map_re),
		.raddr (map_raddr),
		.rdata (map_rdata)
	);

	// camera coordinate
	logic [45:0] cam_prod;
	assign cam_prod = col_q * CAM_M;

	// ray direction
	logic signed [15:0]      pl_sel, dir_sel;
	logic signed [41:0]      ray_prod;
	logic signed [RX_W-1:0]  ray_n;
	assign pl_sel   = (state_q == ST_RAYX) ? plane_x_q : plane_y_q;
	assign dir_sel  = (state_q == ST_RAYX) ? dir_x_q : dir_y_q;
	assign ray_prod = pl_sel * cam_q;
	assign ray_n    = RX_W'($signed({{12{dir_sel[15]}}, dir_sel}) + ray_prod[41:14]);

	logic [RX_W-1:0] ax, ay;
	assign ax = rx_q[RX_W-1] ? RX_W'(-rx_q) : RX_W'(rx_q);
	assign ay = ry_q[RX_W-1] ? RX_W'(-ry_q) : RX_W'(ry_q);

	// initial side distance
	logic              sel_x;
	logic [10:0]       frac;
	logic [DLT_W-1:0]  d_sel;
	logic              neg_sel;
	logic [9:0]        pf_sel;
	logic [35:0]       side_prod;
	logic [SIDE_W-1:0] side_init;
	assign sel_x     = (state_q == ST_SIDEX);
	assign neg_sel   = sel_x ? rx_q[RX_W-1] : ry_q[RX_W-1];
	assign pf_sel    = sel_x ? px_q[9:0] : py_q[9:0];
	assign d_sel     = sel_x ? dx_q : dy_q;
	assign frac      = neg_sel ? {1'b0, pf_sel} : 11'd1024 - {1'b0, pf_sel};
	assign side_prod = frac * d_sel[24:0];
	assign side_init = (d_sel == DELTA_SAT) ? SIDE_W'({frac, 22'd0})
		: SIDE_W'(side_prod[35:10]);

	// one DDA step
	logic                    step_x;
	logic signed [POS_W-1:0] mx_n, my_n;
	logic                    oob_n;
	assign step_x = sx_q < sy_q;
	assign mx_n   = step_x ? (rx_q[RX_W-1] ? mx_q - 1'b1 : mx_q + 1'b1) : mx_q;
	assign my_n   = step_x ? my_q : (ry_q[RX_W-1] ? my_q - 1'b1 : my_q + 1'b1);
	assign oob_n  = (mx_n < 0) || (mx_n >= $signed(POS_W'(MAP_WIDTH)))
		|| (my_n < 0) || (my_n >= $signed(POS_W'(MAP_HEIGHT)));

	// perpendicular distance
	logic [SIDE_W-1:0] perp_raw;
	logic [DEPTH_W-1:0] perp_n;
	assign perp_raw = side_q ? sy_q - SIDE_W'(dy_q) : sx_q - SIDE_W'(dx_q);
	always_comb begin
		if (perp_raw == '0) begin
			perp_n = DEPTH_W'(1);
		end else if (perp_raw > SIDE_W'(DEPTH_MAX)) begin
			perp_n = DEPTH_MAX;
		end else begin
			perp_n = perp_raw[DEPTH_W-1:0];
		end
	end

	// wall rows and color
	logic signed [NUM_W+1:0] top_raw, bot_raw, top_c, bot_c, split_c;
	logic [23:0]             base_col, fin_col;
	assign top_raw = $signed((NUM_W+2)'(HALF_VH)) - $signed({2'b00, line_q >> 1});
	assign bot_raw = $signed((NUM_W+2)'(HALF_VH)) + $signed({2'b00, line_q >> 1});
	assign top_c   = (top_raw < 0) ? '0 : top_raw;
	assign bot_c   = (bot_raw > $signed((NUM_W+2)'(VIEW_HEIGHT - 1)))
		? (NUM_W+2)'(VIEW_HEIGHT - 1) : bot_raw;
	assign split_c = bot_c + ($signed((NUM_W+2)'(VIEW_HEIGHT - 1)) - bot_c) / 2;
	always_comb begin
		if (wtype_q == 8'd2) begin
			base_col = side_q ? t2_ew_q : t2_ns_q;
		end else begin
			base_col = side_q ? t1_ew_q : t1_ns_q;
		end
	end
	assign fin_col = (perp_q > fog_q) ? dim_color(base_col) : base_col;

	// output register
	logic        out_valid_q;
	logic [8:0]  o_col_q;
	logic [17:0] o_depth_q;
	logic [7:0]  o_top_q, o_bot_q, o_split_q;
	logic [23:0] o_color_q;
	logic        o_side_q;
	logic        out_free, fin_load;

	assign out_free = ~out_valid_q | cast_out.ready;
	assign fin_load = (state_q == ST_FIN) & out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fin_load) begin
			out_valid_q <= 1'b1;
		end else if (cast_out.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fin_load) begin
			o_col_q   <= col_q;
			o_depth_q <= perp_q;
			o_top_q   <= top_c[7:0];
			o_bot_q   <= bot_c[7:0];
			o_split_q <= split_c[7:0];
			o_color_q <= fin_col;
			o_side_q  <= side_q;
		end
	end

	assign cast_out.valid       = out_valid_q;
	assign cast_out.out_column  = o_col_q;
	assign cast_out.depth       = o_depth_q;
	assign cast_out.wall_top    = o_top_q;
	assign cast_out.wall_bottom = o_bot_q;
	assign cast_out.floor_split = o_split_q;
	assign cast_out.wall_color  = o_color_q;
	assign cast_out.hit_side    = o_side_q;

	assign cast_in.ready = (state_q == ST_IDLE);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			div_start_q <= 1'b0;
		end else begin
			div_start_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (in_acc && cast_in.mode) begin
						state_q <= ST_CAM;
					end
				end
				ST_CAM:   state_q <= ST_RAYX;
				ST_RAYX:  state_q <= ST_RAYY;
				ST_RAYY: begin
					div_start_q <= 1'b1;
					state_q     <= ST_DX;
				end
				ST_DX: begin
					if (div_rsp.done) begin
						div_start_q <= 1'b1;
						state_q     <= ST_DY;
					end
				end
				ST_DY:    if (div_rsp.done) state_q <= ST_SIDEX;
				ST_SIDEX: state_q <= ST_SIDEY;
				ST_SIDEY: state_q <= ST_STEP;
				ST_STEP:  state_q <= oob_n ? ST_PERP : ST_RD;
				ST_RD:    state_q <= ST_CHK;
				ST_CHK: begin
					if (map_rdata != 8'd0 || k_q == STEP_W'(STEP_MAX)) begin
						state_q <= ST_PERP;
					end else begin
						state_q <= ST_STEP;
					end
				end
				ST_PERP: begin
					div_start_q <= 1'b1;
					state_q     <= ST_LINE;
				end
				ST_LINE:  if (div_rsp.done) state_q <= ST_FIN;
				ST_FIN:   if (out_free) state_q <= ST_IDLE;
				default:  state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				col_q     <= cast_in.column;
				px_q      <= cast_in.pos_x;
				py_q      <= cast_in.pos_y;
				dir_x_q   <= cast_in.dir_x;
				dir_y_q   <= cast_in.dir_y;
				plane_x_q <= cast_in.plane_x;
				plane_y_q <= cast_in.plane_y;
			end
			ST_CAM: cam_q <= $signed({1'b0, cam_prod[45:21]}) - CAM_W'(16384);
			ST_RAYX: rx_q <= ray_n;
			ST_RAYY: begin
				ry_q      <= ray_n;
				div_num_q <= DELTA_NUM;
				div_den_q <= ax;
			end
			ST_DX: begin
				dx_q      <= (rx_q == '0) ? DELTA_SAT : DLT_W'(div_rsp.quo);
				div_den_q <= ay;
			end
			ST_DY: dy_q <= (ry_q == '0) ? DELTA_SAT : DLT_W'(div_rsp.quo);
			ST_SIDEX: begin
				sx_q  <= side_init;
				mx_q  <= POS_W'(px_q[15:10]);
				my_q  <= POS_W'(py_q[15:10]);
				k_q   <= '0;
			end
			ST_SIDEY: sy_q <= side_init;
			ST_STEP: begin
				// advance the nearer axis; ties go to y
				if (step_x) begin
					sx_q <= sx_q + SIDE_W'(dx_q);
				end else begin
					sy_q <= sy_q + SIDE_W'(dy_q);
				end
				mx_q    <= mx_n;
				my_q    <= my_n;
				side_q  <= ~step_x;
				k_q     <= k_q + 1'b1;
				wtype_q <= 8'd1;
			end
			ST_CHK: begin
				if (map_rdata != 8'd0) begin
					wtype_q <= map_rdata;
				end
			end
			ST_PERP: begin
				perp_q    <= perp_n;
				div_num_q <= NUM_W'(VIEW_HEIGHT * 1024);
				div_den_q <= DEN_W'(perp_n);
			end
			ST_LINE: line_q <= div_rsp.quo;
			default: ;
		endcase
	end

	`DDA_ASSERT_SAME(a_div_done_wait, clk, arst_n, div_rsp.done, (state_q == ST_DX) || (state_q == ST_DY) || (state_q == ST_LINE))
	`DDA_ASSERT_SAME(a_read_in_map, clk, arst_n, map_re, (mx_q >= 0) && (my_q >= 0) && (mx_q < $signed(POS_W'(MAP_WIDTH))) && (my_q < $signed(POS_W'(MAP_HEIGHT))))
	`DDA_ASSERT_NEXT(a_load_from_fin, clk, arst_n, fin_load, out_valid_q && (state_q == ST_IDLE))
endmodule
